FILE: sv/tps_pkg.sv
// Shared types and constants for the tile pixel shifter.
// No dependencies; used by tps_dot_logic and tile_pixel_shifter.
package tps_pkg;

  localparam int TILE_WIDTH = 8;
  localparam int CNT_W      = 4;
  localparam logic [CNT_W-1:0] TILE_COUNT = CNT_W'(TILE_WIDTH);

  // Command codes carried in the input tuser
  typedef enum logic [1:0] {
    CMD_DOT      = 2'd0,
    CMD_PREFETCH = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_e_t;

  // Frame write actions
  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_BACKDROP = 2'd1;
  localparam logic [1:0] ACT_COLOR    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_FINE_SCROLL  = 2'd0;
  localparam logic [1:0] REG_CLIP_LEFT    = 2'd1;
  localparam logic [1:0] REG_LAYER_ENABLE = 2'd2;

  // Leftmost column range hidden by clipping
  localparam logic [7:0] CLIP_LAST_X = 8'd7;

  typedef struct packed {
    logic [2:0] fine_scroll;
    logic       clip_left;
    logic       layer_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       low_shifter;
    logic [7:0]       high_shifter;
    logic [7:0]       low_feed;
    logic [7:0]       high_feed;
    logic [7:0]       current_attr;
    logic [2:0]       current_shift;
    logic [7:0]       next_attr;
    logic [2:0]       next_shift;
    logic [CNT_W-1:0] dot_counter;
  } shift_state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       rendering;
    logic [7:0] pixel_x;
    logic [7:0] pattern_low;
    logic [7:0] pattern_high;
    logic [7:0] attr_byte;
    logic [2:0] attr_shift;
  } dot_item_t;

  typedef struct packed {
    logic [3:0] color_index;
    logic [1:0] frame_action;
    logic [1:0] bg_pixel;
  } dot_result_t;

endpackage

FILE: sv/tps_dot_logic.sv
// Combinational next-state and pixel result for one item of the shifter.
// Depends on tps_pkg.
module tps_dot_logic (
  input  tps_pkg::shift_state_t st,
  input  tps_pkg::cfg_t         cfg,
  input  tps_pkg::dot_item_t    item,
  output tps_pkg::shift_state_t st_nxt,
  output logic                  res_valid,
  output tps_pkg::dot_result_t  res
);

  logic [tps_pkg::CNT_W-1:0] cnt_dec;
  logic                      load;
  logic [7:0]                low_feed_ld;
  logic [7:0]                high_feed_ld;
  logic [7:0]                cur_attr_ld;
  logic [2:0]                cur_shift_ld;
  logic [7:0]                nxt_attr_ld;
  logic [2:0]                nxt_shift_ld;
  logic [tps_pkg::CNT_W-1:0] cnt_ld;
  logic [2:0]                tap;
  logic [1:0]                pix;
  logic [7:0]                attr_sel;
  logic [2:0]                shift_sel;
  logic [7:0]                attr_shifted;
  logic [1:0]                pal;
  logic                      clipped;

  // Count down the dot counter and reload the tile when it expires
  always_comb begin
    cnt_dec      = (st.dot_counter != '0) ? st.dot_counter - 1'b1 : '0;
    load         = (cnt_dec == '0);
    low_feed_ld  = load ? item.pattern_low  : st.low_feed;
    high_feed_ld = load ? item.pattern_high : st.high_feed;
    cur_attr_ld  = load ? st.next_attr      : st.current_attr;
    cur_shift_ld = load ? st.next_shift     : st.current_shift;
    nxt_attr_ld  = load ? item.attr_byte    : st.next_attr;
    nxt_shift_ld = load ? item.attr_shift   : st.next_shift;
    cnt_ld       = load ? tps_pkg::TILE_COUNT : cnt_dec;
  end

  // Pick the pixel at the fine scroll tap and the palette of its tile
  always_comb begin
    tap          = 3'd7 - cfg.fine_scroll;
    pix          = {st.high_shifter[tap], st.low_shifter[tap]};
    if (cnt_ld <= {1'b0, cfg.fine_scroll}) begin
      attr_sel  = nxt_attr_ld;
      shift_sel = nxt_shift_ld;
    end else begin
      attr_sel  = cur_attr_ld;
      shift_sel = cur_shift_ld;
    end
    attr_shifted = attr_sel >> shift_sel;
    pal          = attr_shifted[1:0];
    clipped      = cfg.clip_left && (item.pixel_x <= tps_pkg::CLIP_LAST_X);
  end

  // Apply the command to the state and form the result
  always_comb begin
    st_nxt    = st;
    res_valid = 1'b0;
    res       = '0;
    unique case (tps_pkg::cmd_e_t'(item.cmd))
      tps_pkg::CMD_DOT: begin
        res_valid           = 1'b1;
        st_nxt.low_shifter  = {st.low_shifter[6:0], low_feed_ld[7]};
        st_nxt.high_shifter = {st.high_shifter[6:0], high_feed_ld[7]};
        st_nxt.low_feed     = {low_feed_ld[6:0], 1'b0};
        st_nxt.high_feed    = {high_feed_ld[6:0], 1'b0};
        st_nxt.current_attr  = cur_attr_ld;
        st_nxt.current_shift = cur_shift_ld;
        st_nxt.next_attr     = nxt_attr_ld;
        st_nxt.next_shift    = nxt_shift_ld;
        st_nxt.dot_counter   = cnt_ld;
        if (item.rendering) begin
          if ((pix == 2'd0) || clipped) begin
            res.frame_action = tps_pkg::ACT_BACKDROP;
          end else begin
            res.bg_pixel = pix;
            if (cfg.layer_enable) begin
              res.frame_action = tps_pkg::ACT_COLOR;
              res.color_index  = {pal, pix};
            end
          end
        end
      end
      tps_pkg::CMD_PREFETCH: begin
        st_nxt.low_shifter   = st.low_feed;
        st_nxt.high_shifter  = st.high_feed;
        st_nxt.low_feed      = item.pattern_low;
        st_nxt.high_feed     = item.pattern_high;
        st_nxt.current_attr  = st.next_attr;
        st_nxt.current_shift = st.next_shift;
        st_nxt.next_attr     = item.attr_byte;
        st_nxt.next_shift    = item.attr_shift;
        st_nxt.dot_counter   = tps_pkg::TILE_COUNT;
      end
      tps_pkg::CMD_CLEAR: begin
        st_nxt = '0;
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

endmodule

FILE: sv/tile_pixel_shifter.sv
// Tile pixel shifter: each result is registered in out_data_r, or in the skid entry while
// out_* stalls. Throughput 1 item per cycle while the skid entry is empty; the state update
// of each item finishes in the cycle it is accepted, and a two-entry output buffer keeps
// input flowing in a stall until the skid entry fills. Non-dot items give no result.
// Synchronous active-low reset clears all shift state, empties the output
// buffer and sets fine_scroll 0, clip_left 0, layer_enable 1; needs tps_pkg, tps_dot_logic.
module tile_pixel_shifter (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: pixel_x[7:0], pattern_low[15:8], pattern_high[23:16],
  //        attr_byte[31:24], attr_shift[34:32], zero[39:35]
  input  logic [39:0] in_tdata,
  // tuser: cmd[1:0], rendering[2]
  input  logic [2:0]  in_tuser,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: bg_pixel[1:0], frame_action[3:2], color_index[7:4]
  output logic [7:0]  out_tdata
);

  tps_pkg::cfg_t         cfg_r;
  tps_pkg::shift_state_t st_r;
  tps_pkg::shift_state_t st_nxt;
  tps_pkg::dot_item_t    item;
  tps_pkg::dot_result_t  res;
  tps_pkg::dot_result_t  out_data_r;
  tps_pkg::dot_result_t  skid_data_r;
  logic                  res_valid;
  logic                  out_valid_r;
  logic                  skid_valid_r;
  logic                  in_xfer;
  logic                  out_xfer;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_valid_r && out_tready;

  // Unpack the input transfer
  always_comb begin
    item.cmd          = in_tuser[1:0];
    item.rendering    = in_tuser[2];
    item.pixel_x      = in_tdata[7:0];
    item.pattern_low  = in_tdata[15:8];
    item.pattern_high = in_tdata[23:16];
    item.attr_byte    = in_tdata[31:24];
    item.attr_shift   = in_tdata[34:32];
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fine_scroll  <= 3'd0;
      cfg_r.clip_left    <= 1'b0;
      cfg_r.layer_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tps_pkg::REG_FINE_SCROLL:  cfg_r.fine_scroll  <= cfg_data;
        tps_pkg::REG_CLIP_LEFT:    cfg_r.clip_left    <= cfg_data[0];
        tps_pkg::REG_LAYER_ENABLE: cfg_r.layer_enable <= cfg_data[0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  tps_dot_logic u_dot (
    .st        (st_r),
    .cfg       (cfg_r),
    .item      (item),
    .st_nxt    (st_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  // Advance shift state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  // Output register with one skid entry
  assign in_tready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_tready) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_xfer && res_valid;
    end else if (in_xfer && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
      end
    end else if (!out_valid_r || out_tready) begin
      out_data_r <= res;
    end else begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // Skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // Dot counter never exceeds one tile
  a_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.dot_counter <= tps_pkg::TILE_COUNT)
    else $error("dot counter beyond tile width");

  // Frame clear empties the shifters and counter
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (item.cmd == tps_pkg::CMD_CLEAR)) |=>
      (st_r.dot_counter == '0) && (st_r.low_shifter == '0) &&
      (st_r.high_shifter == '0))
    else $error("frame clear left state behind");

  // A dot taken with output free shows a result next cycle
  a_dot_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (item.cmd == tps_pkg::CMD_DOT) && (!out_valid_r || out_tready))
      |=> out_valid_r)
    else $error("pixel dot produced no result");
`endif

endmodule
